>>> src/kmp_word_pattern_matcher_assert.svh
// ----------------------------------------------------------------------------
// kmp word pattern matcher assertion macros
// concurrent checks clocked on i_clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef KMP_WORD_PATTERN_MATCHER_ASSERT_SVH
`define KMP_WORD_PATTERN_MATCHER_ASSERT_SVH

// consequent must hold in the same cycle
`define KWPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the next cycle
`define KWPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/kwpm_pkg.sv
// ----------------------------------------------------------------------------
// kwpm_pkg
// shared types, constants and helpers of the kmp word pattern matcher
// ----------------------------------------------------------------------------
package kwpm_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int OFFSET_WIDTH = 16;
    localparam int PAT_IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W        = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int BYTE_W       = 8;
    localparam int RSP_OFF_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO  = 2'd0,
        CFG_PAT_HI  = 2'd1,
        CFG_PAT_LEN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              word_last;
    } t_req;

    typedef struct packed {
        logic                 word_hit;
        logic [RSP_OFF_W-1:0] first_offset;
    } t_rsp;

    typedef struct packed {
        logic shift;
        logic flush;
    } t_cell_ctl;

    typedef struct packed {
        logic accept;
        logic last;
        logic hit;
    } t_trk_ev;

    function automatic logic [BYTE_W-1:0] pat_byte(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input int                    k
    );
        logic [CFG_DATA_W-1:0] w;
        w = ((k % 16) < 8) ? lo : hi;
        return BYTE_W'(w >> ((k % 8) * BYTE_W));
    endfunction

    // index of the last pattern byte in use
    function automatic logic [PAT_IDX_W-1:0] used_last(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] m;
        m = len;
        if (m == '0) begin
            m = LEN_W'(1);
        end
        if (m > LEN_W'(MAX_PATTERN)) begin
            m = LEN_W'(MAX_PATTERN);
        end
        return PAT_IDX_W'(m - LEN_W'(1));
    endfunction

endpackage

>>> src/kmp_word_pattern_matcher.sv
// ----------------------------------------------------------------------------
// kmp_word_pattern_matcher
// finds the first occurrence of a configured pattern in each word of a
// byte stream, using a chain of prefix cells
//
//   channel  direction  handshake                  request
//   text     in         i_valid / o_stall          i_req (byte, word_last)
//   result   out        o_valid / i_stall          o_rsp (hit, first_offset)
//   config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one text byte per cycle while o_stall is low; every cell updates in the same cycle
// the result is registered and shows in the cycle after the last byte of a word
// a last byte waits only while a previous result is held by i_stall
// config writes to a known index clear the cell chain; synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
module kmp_word_pattern_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  kwpm_pkg::t_req                      i_req,
    output logic                                o_stall,
    output logic                                o_valid,
    output kwpm_pkg::t_rsp                      o_rsp,
    input  logic                                i_stall,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kwpm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kwpm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [kwpm_pkg::CFG_DATA_W-1:0] r_pat_lo;
    logic [kwpm_pkg::CFG_DATA_W-1:0] r_pat_hi;
    logic [kwpm_pkg::LEN_W-1:0]      r_pat_len;

    logic                             cfg_wr;
    logic                             cfg_known;
    logic                             accept;
    logic                             busy;
    logic [kwpm_pkg::PAT_IDX_W-1:0]   pat_last;
    kwpm_pkg::t_cell_ctl              cell_ctl;
    kwpm_pkg::t_trk_ev                trk_ev;
    logic [kwpm_pkg::MAX_PATTERN-1:0] chain_in;
    logic [kwpm_pkg::MAX_PATTERN-1:0] cell_act;
    logic [kwpm_pkg::MAX_PATTERN-1:0] cell_next;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_comb begin
        case (kwpm_pkg::t_cfg_idx'(i_cfg_index))
            kwpm_pkg::CFG_PAT_LO,
            kwpm_pkg::CFG_PAT_HI,
            kwpm_pkg::CFG_PAT_LEN: cfg_known = cfg_wr;
            default:               cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= kwpm_pkg::LEN_W'(1);
        end else if (cfg_wr) begin
            case (kwpm_pkg::t_cfg_idx'(i_cfg_index))
                kwpm_pkg::CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                kwpm_pkg::CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                kwpm_pkg::CFG_PAT_LEN: r_pat_len <= i_cfg_data[kwpm_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // only a word end needs the result slot
    assign o_stall = i_req.word_last & busy;
    assign accept  = i_valid & !o_stall;

    assign pat_last       = kwpm_pkg::used_last(r_pat_len);
    assign cell_ctl.shift = accept;
    assign cell_ctl.flush = (accept & i_req.word_last) | cfg_known;

    for (genvar k = 0; k < kwpm_pkg::MAX_PATTERN; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign chain_in[k] = 1'b1;
        end else begin : g_link
            assign chain_in[k] = cell_act[k-1];
        end

        kwpm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_byte     (i_req.text_byte),
            .i_pat_byte (kwpm_pkg::pat_byte(r_pat_lo, r_pat_hi, k)),
            .i_prev     (chain_in[k]),
            .o_active   (cell_act[k]),
            .o_next     (cell_next[k])
        );
    end

    assign trk_ev.accept = accept;
    assign trk_ev.last   = i_req.word_last;
    assign trk_ev.hit    = cell_next[pat_last];

    kwpm_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev       (trk_ev),
        .i_pat_last (pat_last),
        .i_stall    (i_stall),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

endmodule

>>> src/kwpm_cell.sv
// ----------------------------------------------------------------------------
// kwpm_cell
// one pattern position: flags that the pattern prefix ending here matches
// the text ending at the latest byte
// ----------------------------------------------------------------------------
module kwpm_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kwpm_pkg::t_cell_ctl               i_ctl,
    input  logic [kwpm_pkg::BYTE_W-1:0]       i_byte,
    input  logic [kwpm_pkg::BYTE_W-1:0]       i_pat_byte,
    input  logic                              i_prev,
    output logic                              o_active,
    output logic                              o_next
);

    logic r_active;
    logic n_active;

    always_comb begin
        o_next   = i_prev & (i_byte == i_pat_byte);
        n_active = r_active;
        if (i_ctl.flush) begin
            n_active = 1'b0;
        end else if (i_ctl.shift) begin
            n_active = o_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    assign o_active = r_active;

endmodule

>>> src/kwpm_track.sv
// ----------------------------------------------------------------------------
// kwpm_track
// word offset counter, first hit capture and result register
// ----------------------------------------------------------------------------
module kwpm_track (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kwpm_pkg::t_trk_ev                 i_ev,
    input  logic [kwpm_pkg::PAT_IDX_W-1:0]    i_pat_last,
    input  logic                              i_stall,
    output logic                              o_busy,
    output logic                              o_valid,
    output kwpm_pkg::t_rsp                    o_rsp
);

    localparam logic [kwpm_pkg::OFFSET_WIDTH-1:0] OFF_MAX = '1;

    logic [kwpm_pkg::OFFSET_WIDTH-1:0] r_word_off, n_word_off;
    logic [kwpm_pkg::OFFSET_WIDTH-1:0] r_hit_off, n_hit_off;
    logic                              r_hit_seen, n_hit_seen;
    logic                              r_out_valid, n_out_valid;
    kwpm_pkg::t_rsp                    r_rsp, n_rsp;

    logic [kwpm_pkg::OFFSET_WIDTH-1:0] cand;
    logic [kwpm_pkg::OFFSET_WIDTH-1:0] off_now;
    logic                              take;
    logic                              hit_now;
    logic                              word_end;

    always_comb begin
        cand     = r_word_off - kwpm_pkg::OFFSET_WIDTH'(i_pat_last);
        take     = i_ev.accept & i_ev.hit & !r_hit_seen;
        hit_now  = r_hit_seen | (i_ev.accept & i_ev.hit);
        off_now  = r_hit_seen ? r_hit_off : cand;
        word_end = i_ev.accept & i_ev.last;

        n_word_off  = r_word_off;
        n_hit_seen  = r_hit_seen;
        n_hit_off   = r_hit_off;
        n_out_valid = r_out_valid;
        n_rsp       = r_rsp;

        if (word_end) begin
            n_word_off = '0;
            n_hit_seen = 1'b0;
            n_hit_off  = '0;
        end else if (i_ev.accept) begin
            if (r_word_off != OFF_MAX) begin
                n_word_off = r_word_off + kwpm_pkg::OFFSET_WIDTH'(1);
            end
            if (take) begin
                n_hit_seen = 1'b1;
                n_hit_off  = cand;
            end
        end

        if (word_end) begin
            n_out_valid        = 1'b1;
            n_rsp.word_hit     = hit_now;
            n_rsp.first_offset = hit_now ? kwpm_pkg::RSP_OFF_W'(off_now) : '0;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_off  <= '0;
            r_hit_seen  <= 1'b0;
            r_hit_off   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_word_off  <= n_word_off;
            r_hit_seen  <= n_hit_seen;
            r_hit_off   <= n_hit_off;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_busy  = r_out_valid & i_stall;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

>>> src/kwpm_checker.sv
// ----------------------------------------------------------------------------
// kwpm_checker
// port level checks of the kmp word pattern matcher
// ----------------------------------------------------------------------------
`include "kmp_word_pattern_matcher_assert.svh"

module kwpm_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  kwpm_pkg::t_req                      i_req,
    input  logic                                o_stall,
    input  logic                                o_valid,
    input  kwpm_pkg::t_rsp                      o_rsp,
    input  logic                                i_stall,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [kwpm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kwpm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    `KWPM_ASSERT_NEXT(a_rsp_held, o_valid && i_stall, o_valid, "result dropped while stalled")
    `KWPM_ASSERT_NEXT(a_rsp_stable, o_valid && i_stall, $stable(o_rsp), "result changed while stalled")
    `KWPM_ASSERT_NOW(a_miss_zero, o_valid && !o_rsp.word_hit, o_rsp.first_offset == '0, "offset set without hit")
    `KWPM_ASSERT_NOW(a_mid_flow, i_valid && !i_req.word_last, !o_stall, "mid-word byte stalled")
    `KWPM_ASSERT_NEXT(a_end_rsp, i_valid && !o_stall && i_req.word_last, o_valid, "word end without result")

endmodule

bind kmp_word_pattern_matcher kwpm_checker u_kwpm_checker (.*);
